@@ src/breath_phase_tracker_top_defines.svh @@
// Assertion macros used by breath_phase_tracker_top.
`ifndef BREATH_PHASE_TRACKER_TOP_DEFINES_SVH
`define BREATH_PHASE_TRACKER_TOP_DEFINES_SVH
`define BPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BPT_ASSERT_KNOWN(lbl, clk, rstn, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !$isunknown(sig)) else $error(msg);
`endif

@@ src/bpt_pkg.sv @@
`timescale 1ns / 1ps
package bpt_pkg;
  localparam int RingDepth = 16;
  localparam int RingAw = $clog2(RingDepth);
  localparam int FlowW = 20;
  localparam logic [1:0] CfgTrigger = 2'd0;
  localparam logic [1:0] CfgCycle = 2'd1;
  localparam logic [1:0] CfgSmooth = 2'd2;
  localparam logic [1:0] CfgGap = 2'd3;
  localparam logic [31:0] RstVolPeak = 32'd460800;
  localparam logic [19:0] RstInPeak = 20'sd6400;
  localparam logic [19:0] RstExPeak = -20'sd6400;
  localparam logic [23:0] RstInTime = 24'd40960;
  localparam logic [23:0] RstExTime = 24'd51200;
endpackage

@@ src/bpt_ram.sv @@
`timescale 1ns / 1ps
module bpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ src/breath_phase_tracker_top.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Group                  | Payload
// input   | in  | s_axis_t*              | tdata flow, progress, support, time
// output  | out | m_axis_t*              | tdata counters and averages, tuser flags
// config  | in  | cfg_we_i/idx/data      | four registers, no read-back
// Each accepted item runs StRead, which reads the eight newest ring samples through
// the single read port, StBlend, which blends five averages one by one, StCalc, which
// updates the tracker, and StOut, which raises m_axis_tvalid, before the next is taken.
// After reset the ring holds undefined data; the fill count masks it.
// A result waits in the output registers while m_axis_tready is low; the next item
// is taken and read, then holds before its blend cycles until that result has gone.
module breath_phase_tracker_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // flow[19:0], progress[35:20], support[51:36], time[83:52], zero fill
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // trigger_count[15:0], cycle_count[31:16], breath_total[47:32],
  // latched_support[63:48], avg_volume_peak[95:64], avg_inhale_ticks[119:96],
  // avg_exhale_ticks[143:120], avg_inhale_peak[163:144],
  // avg_exhale_peak[183:164]
  output logic [183:0] m_axis_tdata,
  // inhaling[0], phase_started[1], breath_valid[2]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import bpt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StBlend = 3'd2;
  localparam logic [2:0] StCalc  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [19:0] trig_q; logic [15:0] cfrac_q, smooth_q; logic [31:0] gap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= 20'd512; cfrac_q <= 16'd16384; smooth_q <= 16'd13107; gap_q <= 32'd100000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTrigger: trig_q <= cfg_data_i[19:0];
        CfgCycle: cfrac_q <= cfg_data_i[15:0];
        CfgSmooth: smooth_q <= cfg_data_i[15:0];
        CfgGap: gap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [2:0] st_q;
  logic [3:0] cnt_q;
  logic signed [19:0] flow_q; logic [15:0] prog_q, sup_q; logic [31:0] now_q;
  logic [RingAw-1:0] ptr_q; logic [3:0] fill_q; logic [31:0] ptime_q;
  logic primed_q, phigh_q, inh_q, valid_q, started_q;
  logic [15:0] tcnt_q, ccnt_q, bcnt_q, slat_q;
  logic [31:0] vol_q, volpk_q; logic signed [19:0] ipk_q, epk_q;
  logic [15:0] iti_q, eti_q;
  logic [31:0] rvol_q; logic signed [19:0] rip_q, rep_q; logic [23:0] rit_q, ret_q;
  logic signed [23:0] dsum_q;
  logic [2:0] bidx_q;
  logic rst_now_q;
  logic vok_q;

  logic ram_we; logic [RingAw-1:0] raddr; logic [19:0] rdata;
  assign ram_we = (st_q == StIdle) && s_axis_tvalid && s_axis_tready;
  assign raddr = ptr_q - RingAw'(cnt_q[2:0]);
  bpt_ram #(.Width(FlowW), .Depth(RingDepth)) u_ring (
    .clk_i, .we_i(ram_we), .waddr_i(ptr_q), .wdata_i(s_axis_tdata[19:0]),
    .raddr_i(raddr), .rdata_o(rdata));

  assign s_axis_tready = (st_q == StIdle);

  function automatic logic signed [35:0] blend_f(input logic signed [33:0] old,
      input logic signed [33:0] fresh, input logic [15:0] c);
    logic signed [51:0] p;
    p = 52'(fresh - old) * $signed({1'b0, c}) + 52'sd32768;
    return 36'(old) + 36'(p >>> 16);
  endfunction

  // Effective per-item state after a restart is folded in.
  logic restart;
  assign restart = !primed_q || ((now_q - ptime_q) > gap_q);
  logic high, chk_ok, blend_go;
  assign high = prog_q > 16'd32768;
  assign chk_ok = (eti_q > 16'd70) && ({eti_q, 8'd0, 2'd0} + {eti_q, 8'd0} >
                  27'({ret_q, 1'b0} + ret_q)) && (iti_q > 16'd70);
  assign blend_go = !rst_now_q && phigh_q && (prog_q < 16'd32768) && vok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic ph, inh, vf, stv; logic [15:0] ti, te, tc, cc, bc;
    logic [31:0] vo, vp; logic signed [19:0] ip, ep;
    logic signed [33:0] v; logic signed [24:0] tr;
    logic signed [36:0] cl, cr;
    logic signed [33:0] bo, bf; logic signed [35:0] bres;
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; ptr_q <= '0; fill_q <= '0; primed_q <= 1'b0;
      m_axis_tvalid <= 1'b0; ptime_q <= '0;
      phigh_q <= 1'b0; inh_q <= 1'b0; valid_q <= 1'b0; tcnt_q <= '0; ccnt_q <= '0;
      bcnt_q <= '0; slat_q <= '0; vol_q <= '0; volpk_q <= '0; ipk_q <= '0;
      epk_q <= '0; iti_q <= '0; eti_q <= '0; rvol_q <= RstVolPeak;
      rip_q <= RstInPeak; rep_q <= RstExPeak; rit_q <= RstInTime; ret_q <= RstExTime;
      dsum_q <= '0; started_q <= 1'b0; rst_now_q <= 1'b0; bidx_q <= '0; vok_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (st_q)
        StIdle: if (ram_we) begin
          flow_q <= s_axis_tdata[19:0]; prog_q <= s_axis_tdata[35:20];
          sup_q <= s_axis_tdata[51:36]; now_q <= s_axis_tdata[83:52];
          cnt_q <= '0; dsum_q <= '0; st_q <= StRead;
        end
        StRead: begin
          // Restart decision is fixed on the first read cycle.
          if (cnt_q == 4'd0) rst_now_q <= restart;
          // Read data is registered in the RAM, so each value belongs to the previous read address; index cnt-1.
          if (cnt_q != 4'd0) begin
            if (cnt_q <= 4'd4) dsum_q <= dsum_q + 24'($signed(rdata));
            else dsum_q <= dsum_q - 24'($signed(rdata));
          end
          if (cnt_q == 4'd8) begin
            if (rst_now_q) begin
              ptr_q <= ptr_q + 1'b1 - ptr_q; fill_q <= 4'd1;
            end else begin
              ptr_q <= ptr_q + 1'b1;
              if (fill_q < 4'd15) fill_q <= fill_q + 1'b1;
            end
            vok_q <= chk_ok; bidx_q <= '0; st_q <= StBlend;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        StBlend: if (!m_axis_tvalid) begin
          case (bidx_q)
            3'd0: begin bo = 34'(rvol_q); bf = 34'(volpk_q); end
            3'd1: begin bo = 34'(rep_q); bf = 34'(epk_q); end
            3'd2: begin bo = 34'(rip_q); bf = 34'(ipk_q); end
            3'd3: begin bo = 34'(rit_q); bf = 34'({iti_q, 8'd0}); end
            default: begin bo = 34'(ret_q); bf = 34'({eti_q, 8'd0}); end
          endcase
          bres = blend_f(bo, bf, smooth_q);
          if (blend_go) begin
            case (bidx_q)
              3'd0: rvol_q <= 32'(bres);
              3'd1: rep_q <= 20'(bres);
              3'd2: rip_q <= 20'(bres);
              3'd3: rit_q <= 24'(bres);
              default: ret_q <= 24'(bres);
            endcase
          end
          bidx_q <= bidx_q + 1'b1;
          if (bidx_q == 3'd4) st_q <= StCalc;
        end
        StCalc: if (!m_axis_tvalid) begin
          ph = rst_now_q ? high : phigh_q;
          inh = rst_now_q ? 1'b0 : inh_q; vf = rst_now_q ? 1'b0 : valid_q;
          ti = rst_now_q ? '0 : iti_q; te = rst_now_q ? '0 : eti_q;
          tc = rst_now_q ? '0 : tcnt_q; cc = rst_now_q ? '0 : ccnt_q;
          bc = rst_now_q ? '0 : bcnt_q;
          vo = rst_now_q ? '0 : vol_q; vp = rst_now_q ? '0 : volpk_q;
          ip = rst_now_q ? '0 : ipk_q; ep = rst_now_q ? '0 : epk_q;
          if (rst_now_q) begin
            rvol_q <= RstVolPeak; rip_q <= RstInPeak;
            rep_q <= RstExPeak; rit_q <= RstInTime; ret_q <= RstExTime;
          end
          stv = 1'b0;
          if (ph && prog_q < 16'd32768) begin
            inh = 1'b1; stv = 1'b1; tc = '0; cc = '0; bc = bc + 1'b1;
            slat_q <= sup_q;
            vf = vok_q;
            vo = '0; vp = '0; ip = '0; ep = '0; ti = '0; te = '0;
          end else if (!ph && high) begin
            inh = 1'b0; stv = 1'b1; tc = '0; cc = '0; slat_q <= sup_q;
          end else if (rst_now_q) begin
            slat_q <= '0;
          end
          if (inh) begin
            if (ti != 16'hFFFF) ti = ti + 1'b1;
            if (flow_q > ip) ip = flow_q;
            cl = 37'($signed({flow_q, 16'd0}));
            cr = 37'(ip * $signed({1'b0, cfrac_q}));
            if (cl < cr) begin if (cc != 16'hFFFF) cc = cc + 1'b1; end
            else if (cc != 16'd0) cc = cc - 1'b1;
          end else begin
            if (te != 16'hFFFF) te = te + 1'b1;
            if (flow_q < ep) ep = flow_q;
            tr = 25'($signed(trig_q));
            if ((25'(flow_q) > tr) || ((25'(flow_q) <<< 1) +
                ((fill_q >= 4'd9 && !rst_now_q) ? 25'(dsum_q) : 25'sd0) > (tr <<< 1))) begin
              if (tc != 16'hFFFF) tc = tc + 1'b1;
            end else tc = '0;
          end
          v = $signed({2'b0, vo}) + 34'(flow_q);
          if (v < 0) vo = '0; else if (v > 34'sh0FFFFFFFF) vo = '1; else vo = v[31:0];
          if (vo > vp) vp = vo;
          started_q <= stv;
          inh_q <= inh; valid_q <= vf; iti_q <= ti; eti_q <= te; tcnt_q <= tc;
          ccnt_q <= cc; bcnt_q <= bc; vol_q <= vo; volpk_q <= vp; ipk_q <= ip;
          epk_q <= ep; phigh_q <= high; ptime_q <= now_q; primed_q <= 1'b1;
          st_q <= StOut;
        end
        StOut: begin
          m_axis_tvalid <= 1'b1; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tdata = {rep_q, rip_q, ret_q, rit_q, rvol_q, slat_q, bcnt_q, ccnt_q, tcnt_q};
  assign m_axis_tuser = {valid_q, started_q, inh_q};

  `include "breath_phase_tracker_top_defines.svh"
  `BPT_ASSERT(a_no_accept_busy, clk_i, rst_ni, (st_q != StIdle) |-> !s_axis_tready, "ready while busy")
  `BPT_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
  `BPT_ASSERT_KNOWN(a_out_valid_known, clk_i, rst_ni, m_axis_tvalid, "output valid unknown")
endmodule
